@@ src/modexp_pkg.sv @@
package modexp_pkg;

   localparam int DefaultWidth = 64;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] exponent;
      logic [63:0] modulus;
   } req_type;

   typedef struct packed {
      logic [63:0] power_result;
      logic        bad_modulus;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture operands
      logic red_start; // begin reducing base mod m
      logic mul_start; // begin a modular multiply
      logic mul_sq;    // 1: sq*sq -> sq, 0: acc*sq -> acc
      logic shift_exp; // drop one exponent bit
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic busy;
      logic exp_zero;
      logic exp_lsb;
      logic mod_zero;
   } status_type;

endpackage

@@ src/modexp_datapath.sv @@
module modexp_datapath #(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  modexp_pkg::req_type   req_data,
   input  modexp_pkg::cmd_type   cmd,
   output modexp_pkg::status_type status,
   output logic [WIDTH-1:0]      acc_out
);
   import modexp_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] mod_ff, exp_ff, acc_ff, sq_ff;
   logic [WIDTH-1:0] mod_in, exp_in, acc_in, sq_in;
   // shift-add multiplier state
   logic [WIDTH-1:0] pacc_ff, pacc_in, mulb_ff, mulb_in, mula_ff, mula_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, red_ff, red_in, sq_sel_ff, sq_sel_in;

   logic [WIDTH:0]   dbl, dbl_r, add, add_r;

   always_comb begin
      // acc = 2*acc mod m; acc < m so one subtract suffices
      dbl   = {pacc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, mod_ff}) ? dbl - {1'b0, mod_ff} : dbl;
      add   = dbl_r + {1'b0, mula_ff};
      add_r = (add >= {1'b0, mod_ff}) ? add - {1'b0, mod_ff} : add;
   end

   always_comb begin
      mod_in = mod_ff; exp_in = exp_ff; acc_in = acc_ff; sq_in = sq_ff;
      pacc_in = pacc_ff; mulb_in = mulb_ff; mula_in = mula_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; red_in = red_ff; sq_sel_in = sq_sel_ff;
      if (cmd.load) begin
         mod_in = req_data.modulus[WIDTH-1:0];
         exp_in = req_data.exponent[WIDTH-1:0];
         sq_in  = req_data.base[WIDTH-1:0];
         acc_in = WIDTH'(1);
      end
      if (cmd.shift_exp) exp_in = exp_ff >> 1;
      if (cmd.red_start) begin
         // base mod m = 1 * base over the same unit; mula=1 mod m
         mula_in = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
         mulb_in = sq_ff; pacc_in = '0; cnt_in = CW'(WIDTH);
         busy_in = 1'b1; red_in = 1'b1;
      end
      if (cmd.mul_start) begin
         mula_in = sq_ff; mulb_in = cmd.mul_sq ? sq_ff : acc_ff;
         pacc_in = '0; cnt_in = CW'(WIDTH); busy_in = 1'b1; red_in = 1'b0;
         sq_sel_in = cmd.mul_sq;
      end
      if (busy_ff) begin
         pacc_in = mulb_ff[WIDTH-1] ? add_r[WIDTH-1:0] : dbl_r[WIDTH-1:0];
         mulb_in = mulb_ff << 1;
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            if (red_ff || sq_sel_ff) sq_in = pacc_in;
            else acc_in = pacc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      mod_ff <= mod_in; exp_ff <= exp_in; acc_ff <= acc_in; sq_ff <= sq_in;
      pacc_ff <= pacc_in; mulb_ff <= mulb_in; mula_ff <= mula_in;
      cnt_ff <= cnt_in; red_ff <= red_in; sq_sel_ff <= sq_sel_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign status.busy     = busy_ff;
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.mod_zero = (mod_ff == '0);
   assign acc_out         = acc_ff;
endmodule

@@ src/modexp_ctrl.sv @@
module modexp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   bad_ff,
   input  modexp_pkg::status_type status,
   output modexp_pkg::cmd_type    cmd
);
   import modexp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_RED   = 7'b0000100,
      S_BIT   = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_SQ    = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      bad_in, wait_ff, wait_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      state_in = state_ff; bad_in = bad_ff; wait_in = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1; state_in = S_CHECK;
         end
         S_CHECK: begin
            bad_in = status.mod_zero;
            if (status.mod_zero || status.exp_zero) state_in = S_DONE;
            else begin
               cmd.red_start = 1'b1; wait_in = 1'b1; state_in = S_RED;
            end
         end
         S_RED: if (!wait_ff && !status.busy) state_in = S_BIT;
         S_BIT: begin
            if (status.exp_zero) state_in = S_DONE;
            else if (status.exp_lsb) begin
               cmd.mul_start = 1'b1; wait_in = 1'b1; state_in = S_MUL;
            end else begin
               cmd.mul_start = 1'b1; cmd.mul_sq = 1'b1; wait_in = 1'b1;
               state_in = S_SQ;
            end
         end
         S_MUL: if (!wait_ff && !status.busy) begin
            cmd.mul_start = 1'b1; cmd.mul_sq = 1'b1; wait_in = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: if (!wait_ff && !status.busy) begin
            cmd.shift_exp = 1'b1; state_in = S_BIT;
         end
         S_DONE: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      bad_ff <= bad_in;
      if (reset) begin
         state_ff <= S_IDLE; wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in; wait_ff <= wait_in;
      end
   end
endmodule

@@ src/modular_exponentiation.sv @@
// Right-to-left square-and-multiply modular exponentiation. One request is
// in flight at a time; req_stall is high from acceptance until the result
// is taken. Each modular multiply runs on one shift-add unit, one product
// bit per cycle, and each exponent bit adds a bit test in S_BIT. A zero
// modulus returns 0 with bad_modulus set; a zero exponent returns 1.
module modular_exponentiation #(
   parameter int WIDTH = modexp_pkg::DefaultWidth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  modexp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output modexp_pkg::rsp_type rsp_data
);
   import modexp_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [WIDTH-1:0] acc;
   logic             bad;

   modexp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .bad_ff(bad), .status, .cmd
   );

   modexp_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock, .reset, .req_data, .cmd, .status, .acc_out(acc)
   );

   assign rsp_data.power_result = bad ? 64'd0 : 64'(acc);
   assign rsp_data.bad_modulus  = bad;

   a_single: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("result valid while accepting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_modulus |-> rsp_data.power_result == 64'd0)
      else $error("bad modulus with nonzero result");
endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import modexp_pkg::*;

   localparam int Width = DefaultWidth;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_powers[$];
   int      mismatch_count;
   bit      stimulus_done;
   int      hold_off_cycles;
   int      burst_left;
   int      gap_left;
   int      stall_left;
   int      run_left;

   modular_exponentiation #(.WIDTH(Width)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] mask_width(logic [63:0] v);
      logic [63:0] m;
      m = (Width == 64) ? '1 : ((64'd1 << Width) - 64'd1);
      return v & m;
   endfunction

   // exact (a*b) mod m using a 128-bit product
   function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a % m} * {64'd0, b % m};
      return 64'(p % {64'd0, m});
   endfunction

   function automatic rsp_type predict_power(req_type r);
      rsp_type     o;
      logic [63:0] b, e, m, acc, sq;
      b = mask_width(r.base);
      e = mask_width(r.exponent);
      m = mask_width(r.modulus);
      o = '0;
      if (m == 0) begin
         o.bad_modulus = 1'b1;
         return o;
      end
      acc = 64'd1;
      sq = b;
      while (e != 0) begin
         if (e[0]) acc = mod_product(acc, sq, m);
         sq = mod_product(sq, sq, m);
         e = e >> 1;
      end
      o.power_result = mask_width(acc);
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] rand_small_exp();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 15));
         1: return 64'($urandom());
         default: return rand64() >> $urandom_range(0, 63);
      endcase
   endfunction

   task automatic queue_request(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      req_type r;
      r.base = b;
      r.exponent = e;
      r.modulus = m;
      pending_reqs.push_back(r);
   endtask

   // driver: bursts with random gaps; the request on the bus stays at the
   // head of the queue until it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_powers.push_back(predict_power(req_data));
            void'(pending_reqs.pop_front());
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 6);
               gap_left <= $urandom_range(0, 1) ? $urandom_range(0, 20) : 0;
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with a long hold-off while stimulus is queued
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         run_left <= 0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 2) == 0) run_left <= $urandom_range(10, 60);
         else stall_left <= $urandom_range(1, 12);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_powers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: %h %b", rsp_data.power_result,
                        rsp_data.bad_modulus);
         end else begin
            rsp_type want;
            want = expected_powers.pop_front();
            if (rsp_data.power_result !== want.power_result ||
                rsp_data.bad_modulus !== want.bad_modulus) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h/%b, got %h/%b",
                           want.power_result, want.bad_modulus,
                           rsp_data.power_result, rsp_data.bad_modulus);
            end
         end
      end
   end

   initial begin
      logic [63:0] m;
      mismatch_count = 0;
      stimulus_done = 1'b0;
      hold_off_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;

      // directed: zero modulus, zero exponent, modulus one, extremes
      queue_request(64'd5, 64'd3, 64'd0);
      queue_request('1, '1, 64'd0);
      queue_request(64'd7, 64'd0, 64'd1);
      queue_request('1, 64'd0, '1);
      queue_request(64'd0, 64'd0, 64'd13);
      queue_request(64'd0, 64'd5, 64'd13);
      queue_request(64'd9, 64'd1, 64'd1);
      queue_request('1, '1, '1);
      queue_request('1, '1, 64'hFFFF_FFFF_FFFF_FFC5);
      queue_request(64'hFFFF_FFFF_FFFF_FFFE, 64'd2, '1);
      queue_request(64'd2, 64'd63, 64'h8000_0000_0000_0000);
      queue_request(64'd3, 64'd1, 64'd2);
      queue_request(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 64'd97);
      queue_request(64'd4, 64'd13, 64'd497);
      queue_request(64'h1234_5678_9ABC_DEF0, 64'h5555_5555_5555_5555,
                    64'hAAAA_AAAA_AAAA_AAAB);

      for (int i = 0; i < 100; i++) begin
         case ($urandom_range(0, 9))
            0: m = 64'd0;
            1: m = 64'($urandom_range(1, 3));
            2: m = 64'($urandom());
            default: m = rand64();
         endcase
         queue_request(rand64(), rand_small_exp(), m);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // long receiver hold-off while the sender keeps offering
      repeat (50) @(posedge clock);
      hold_off_cycles <= 3000;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_powers.size() == 0);
      repeat (2 * Width * (Width + 1) + 100) @(posedge clock);
      if (mismatch_count == 0 && expected_powers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
